FILE: design/abfp_pkg.sv
// Shared types, character codes and helpers for the ball frame parser.
package abfp_pkg;

	// Field counts and widths
	localparam int unsigned FIELD_COUNT = 7;
	localparam int unsigned IDX_W = 3;
	localparam int unsigned VAL_W = 16;

	// Character codes
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// Magnitude limits for a signed 16-bit decimal
	localparam logic [19:0] LIMIT_POS = 20'd32767;
	localparam logic [19:0] LIMIT_NEG = 20'd32768;

	// Result status codes
	typedef enum logic [1:0] {
		ST_FRAME      = 2'd0,
		ST_PARSE_FAIL = 2'd1,
		ST_TOO_LONG   = 2'd2
	} status_t;

	// Parse phases within a line
	typedef enum logic [2:0] {
		PH_B           = 3'd0,
		PH_A           = 3'd1,
		PH_L1          = 3'd2,
		PH_L2          = 3'd3,
		PH_COMMA       = 3'd4,
		PH_FIELD_START = 3'd5,
		PH_AFTER_MINUS = 3'd6,
		PH_DIGITS      = 3'd7
	} phase_t;

	// Input item
	typedef struct packed {
		logic [7:0]  rx_byte;
		logic [31:0] time_ms;
	} in_item_t;

	// Published record and counters as seen on the output
	typedef struct packed {
		logic              target_valid;
		logic signed [15:0] x_pos;
		logic signed [15:0] err_m11;
		logic signed [15:0] err_m5;
		logic signed [15:0] err_zero;
		logic signed [15:0] err_p5;
		logic signed [15:0] err_p11;
		logic [31:0]       stamp_ms;
		logic [31:0]       frames_seen;
		logic [31:0]       errors_seen;
	} pub_view_t;

	// Result item
	typedef struct packed {
		logic [1:0]        status;
		logic              target_valid;
		logic signed [15:0] x_pos;
		logic signed [15:0] err_m11;
		logic signed [15:0] err_m5;
		logic signed [15:0] err_zero;
		logic signed [15:0] err_p5;
		logic signed [15:0] err_p11;
		logic [31:0]       stamp_ms;
		logic [31:0]       frames_seen;
		logic [31:0]       errors_seen;
	} out_item_t;

	// Per-line parse state
	typedef struct packed {
		phase_t           phase;
		logic             neg_sign;
		logic [VAL_W-1:0] magnitude;
		logic             line_bad;
		logic             text_ended;
		logic [IDX_W-1:0] field_idx;
	} line_state_t;

	localparam line_state_t LINE_CLEAR = '{
		phase: PH_B, neg_sign: 1'b0, magnitude: '0,
		line_bad: 1'b0, text_ended: 1'b0, field_idx: '0
	};

	// Field store write request
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] value;
	} field_wr_t;

	// Record update request
	typedef struct packed {
		logic                              publish;
		logic                              bump_err;
		logic [FIELD_COUNT-1:0][VAL_W-1:0] vals;
		logic [31:0]                       stamp;
	} rec_upd_t;

	// Two's complement value of the field being parsed
	function automatic logic [VAL_W-1:0] cur_value(input logic neg, input logic [VAL_W-1:0] mag);
		cur_value = neg ? (VAL_W'(0) - mag) : mag;
	endfunction

endpackage

FILE: design/abfp_line_step.sv
// One-byte step of the per-line parser: header, separators and decimal fields.
module abfp_line_step (
	input  logic [7:0]          rx_byte,
	input  abfp_pkg::line_state_t cur,
	output abfp_pkg::line_state_t nxt,
	output abfp_pkg::field_wr_t   fwr
);

	logic        is_digit;
	logic [3:0]  digit;
	logic        eff_neg;
	logic [15:0] eff_mag;
	logic [19:0] prod;
	logic [19:0] limit;
	logic        over;

	// Digit accumulate with overflow check
	always_comb begin
		is_digit = (rx_byte >= abfp_pkg::CH_ZERO) && (rx_byte <= abfp_pkg::CH_NINE);
		digit    = 4'(rx_byte - abfp_pkg::CH_ZERO);
		eff_neg  = (cur.phase == abfp_pkg::PH_FIELD_START) ? 1'b0 : cur.neg_sign;
		eff_mag  = (cur.phase == abfp_pkg::PH_FIELD_START) ? 16'd0 : cur.magnitude;
		prod     = {1'b0, eff_mag, 3'b000} + {3'b000, eff_mag, 1'b0} + {16'd0, digit};
		limit    = eff_neg ? abfp_pkg::LIMIT_NEG : abfp_pkg::LIMIT_POS;
		over     = prod > limit;
	end

	// Phase transitions
	always_comb begin
		nxt = cur;
		fwr = '0;
		unique case (cur.phase) inside
			abfp_pkg::PH_B: begin
				if (rx_byte == abfp_pkg::CH_B) nxt.phase = abfp_pkg::PH_A;
				else nxt.line_bad = 1'b1;
			end
			abfp_pkg::PH_A: begin
				if (rx_byte == abfp_pkg::CH_A) nxt.phase = abfp_pkg::PH_L1;
				else nxt.line_bad = 1'b1;
			end
			abfp_pkg::PH_L1: begin
				if (rx_byte == abfp_pkg::CH_L) nxt.phase = abfp_pkg::PH_L2;
				else nxt.line_bad = 1'b1;
			end
			abfp_pkg::PH_L2: begin
				if (rx_byte == abfp_pkg::CH_L) nxt.phase = abfp_pkg::PH_COMMA;
				else nxt.line_bad = 1'b1;
			end
			abfp_pkg::PH_COMMA: begin
				if (rx_byte == abfp_pkg::CH_COMMA) begin
					nxt.phase     = abfp_pkg::PH_FIELD_START;
					nxt.field_idx = '0;
				end else begin
					nxt.line_bad = 1'b1;
				end
			end
			abfp_pkg::PH_FIELD_START, abfp_pkg::PH_AFTER_MINUS: begin
				nxt.neg_sign  = eff_neg;
				nxt.magnitude = eff_mag;
				if (cur.phase == abfp_pkg::PH_FIELD_START && rx_byte == abfp_pkg::CH_MINUS) begin
					nxt.neg_sign = 1'b1;
					nxt.phase    = abfp_pkg::PH_AFTER_MINUS;
				end else if (is_digit && !over) begin
					nxt.magnitude = prod[15:0];
					nxt.phase     = abfp_pkg::PH_DIGITS;
				end else begin
					nxt.line_bad = 1'b1;
				end
			end
			abfp_pkg::PH_DIGITS: begin
				if (is_digit) begin
					if (over) begin
						nxt.line_bad = 1'b1;
					end else begin
						nxt.magnitude = prod[15:0];
					end
				end else if (rx_byte == abfp_pkg::CH_COMMA &&
						cur.field_idx < abfp_pkg::IDX_W'(abfp_pkg::FIELD_COUNT - 1)) begin
					// close this field and move to the next
					fwr.we        = 1'b1;
					fwr.idx       = cur.field_idx;
					fwr.value     = abfp_pkg::cur_value(cur.neg_sign, cur.magnitude);
					nxt.field_idx = cur.field_idx + abfp_pkg::IDX_W'(1);
					nxt.phase     = abfp_pkg::PH_FIELD_START;
				end else begin
					nxt.line_bad = 1'b1;
				end
			end
			default: nxt.line_bad = 1'b1;
		endcase
	end

endmodule

FILE: design/abfp_record.sv
// Published frame record, timestamp and the frame and error counters.
module abfp_record (
	input  logic                clk,
	input  logic                arst_n,
	input  abfp_pkg::rec_upd_t  upd,
	output abfp_pkg::pub_view_t view_next
);

	logic                    valid_q;
	logic [15:0]             vals_q [1:abfp_pkg::FIELD_COUNT-1];
	logic [31:0]             stamp_q;
	logic [31:0]             frames_q;
	logic [31:0]             errors_q;
	logic [31:0]             frames_inc;

	// Next record and counters
	always_comb begin
		frames_inc = frames_q + 32'd1;
		if (frames_inc == 32'd0) frames_inc = 32'd1;
		view_next.target_valid = valid_q;
		view_next.x_pos        = vals_q[1];
		view_next.err_m11      = vals_q[2];
		view_next.err_m5       = vals_q[3];
		view_next.err_zero     = vals_q[4];
		view_next.err_p5       = vals_q[5];
		view_next.err_p11      = vals_q[6];
		view_next.stamp_ms     = stamp_q;
		view_next.frames_seen  = frames_q;
		view_next.errors_seen  = errors_q;
		if (upd.publish) begin
			view_next.target_valid = upd.vals[0][0];
			view_next.x_pos        = upd.vals[1];
			view_next.err_m11      = upd.vals[2];
			view_next.err_m5       = upd.vals[3];
			view_next.err_zero     = upd.vals[4];
			view_next.err_p5       = upd.vals[5];
			view_next.err_p11      = upd.vals[6];
			view_next.stamp_ms     = upd.stamp;
			view_next.frames_seen  = frames_inc;
		end
		if (upd.bump_err) view_next.errors_seen = errors_q + 32'd1;
	end

	// Record registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			vals_q[1] <= 16'hFFFF;
			for (int i = 2; i < abfp_pkg::FIELD_COUNT; i++) vals_q[i] <= 16'd0;
			stamp_q  <= '0;
			frames_q <= '0;
			errors_q <= '0;
		end else begin
			valid_q   <= view_next.target_valid;
			vals_q[1] <= view_next.x_pos;
			vals_q[2] <= view_next.err_m11;
			vals_q[3] <= view_next.err_m5;
			vals_q[4] <= view_next.err_zero;
			vals_q[5] <= view_next.err_p5;
			vals_q[6] <= view_next.err_p11;
			stamp_q   <= view_next.stamp_ms;
			frames_q  <= view_next.frames_seen;
			errors_q  <= view_next.errors_seen;
		end
	end

endmodule

FILE: design/ascii_ball_frame_parser.sv
// Top level of the streaming parser for BALL text lines.
//
// Parses "BALL,v,x,e1,e2,e3,e4,e5" lines one byte per item. Each accepted byte
// is held in an input register and processed once the result register can move;
// any result (frame published, parse failure, or line too long) lands in the output
// register at the end of the cycle in which its line feed or overlong byte is
// processed. The block takes one byte every cycle while results are drained; a held
// result stalls only once the input register is also full.
// Carriage returns are ignored; a zero byte ends the parsable text of a line.
// Lines longer than LINE_BUF_SIZE-1 bytes give a too-long result and are dropped
// up to the next line feed. No clearing pass is needed after reset.
module ascii_ball_frame_parser #(
	parameter int LINE_BUF_SIZE = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  abfp_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output abfp_pkg::out_item_t out_item
);

	localparam int CW = $clog2(LINE_BUF_SIZE);

	abfp_pkg::in_item_t    item_s1;
	logic                  valid_s1;
	logic                  advance;
	logic                  fire;

	logic                  dropping_q, dropping_d;
	logic [CW-1:0]         char_count_q, char_count_d;
	abfp_pkg::line_state_t line_q, line_d, line_step;
	abfp_pkg::field_wr_t   fwr_step, fwr;
	logic [15:0]           field_vals_q [abfp_pkg::FIELD_COUNT];
	abfp_pkg::rec_upd_t    upd;
	abfp_pkg::pub_view_t   view_next;
	logic                  emit;
	abfp_pkg::status_t     status;
	logic                  line_ok;
	logic [7:0]            c;

	// Handshake: input register frees whenever the result register can move
	assign advance  = !out_valid || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) item_s1 <= in_item;
	end

	abfp_line_step u_step (
		.rx_byte (item_s1.rx_byte),
		.cur     (line_q),
		.nxt     (line_step),
		.fwr     (fwr_step)
	);

	// Line control: CR, LF, dropping and the length limit
	always_comb begin
		c            = item_s1.rx_byte;
		line_d       = line_q;
		char_count_d = char_count_q;
		dropping_d   = dropping_q;
		fwr          = '0;
		emit         = 1'b0;
		status       = abfp_pkg::ST_FRAME;
		upd          = '0;
		upd.stamp    = item_s1.time_ms;
		for (int i = 0; i < abfp_pkg::FIELD_COUNT - 1; i++) upd.vals[i] = field_vals_q[i];
		upd.vals[abfp_pkg::FIELD_COUNT-1] =
			abfp_pkg::cur_value(line_q.neg_sign, line_q.magnitude);
		line_ok = !line_q.line_bad && line_q.phase == abfp_pkg::PH_DIGITS &&
			line_q.field_idx == abfp_pkg::IDX_W'(abfp_pkg::FIELD_COUNT - 1) &&
			field_vals_q[0] <= 16'd1;
		if (fire) begin
			if (c == abfp_pkg::CH_CR) begin
				// ignored
			end else if (c == abfp_pkg::CH_LF) begin
				line_d       = abfp_pkg::LINE_CLEAR;
				char_count_d = '0;
				if (dropping_q) begin
					dropping_d = 1'b0;
				end else begin
					emit         = 1'b1;
					status       = line_ok ? abfp_pkg::ST_FRAME : abfp_pkg::ST_PARSE_FAIL;
					upd.publish  = line_ok;
					upd.bump_err = !line_ok;
				end
			end else if (dropping_q) begin
				// rest of an overlong line
			end else if (char_count_q == CW'(LINE_BUF_SIZE - 1)) begin
				line_d       = abfp_pkg::LINE_CLEAR;
				char_count_d = '0;
				dropping_d   = 1'b1;
				emit         = 1'b1;
				status       = abfp_pkg::ST_TOO_LONG;
				upd.bump_err = 1'b1;
			end else begin
				char_count_d = char_count_q + CW'(1);
				if (!line_q.text_ended && !line_q.line_bad) begin
					if (c == abfp_pkg::CH_NUL) begin
						line_d.text_ended = 1'b1;
					end else begin
						line_d = line_step;
						fwr    = fwr_step;
					end
				end
			end
		end
	end

	// Line state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dropping_q   <= 1'b0;
			char_count_q <= '0;
			line_q       <= abfp_pkg::LINE_CLEAR;
		end else begin
			dropping_q   <= dropping_d;
			char_count_q <= char_count_d;
			line_q       <= line_d;
		end
	end

	// Field store, written as each comma closes a field
	always_ff @(posedge clk) begin
		if (fwr.we) field_vals_q[fwr.idx] <= fwr.value;
	end

	abfp_record u_record (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (upd),
		.view_next (view_next)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_item.status       <= status;
			out_item.target_valid <= view_next.target_valid;
			out_item.x_pos        <= view_next.x_pos;
			out_item.err_m11      <= view_next.err_m11;
			out_item.err_m5       <= view_next.err_m5;
			out_item.err_zero     <= view_next.err_zero;
			out_item.err_p5       <= view_next.err_p5;
			out_item.err_p11      <= view_next.err_p11;
			out_item.stamp_ms     <= view_next.stamp_ms;
			out_item.frames_seen  <= view_next.frames_seen;
			out_item.errors_seen  <= view_next.errors_seen;
		end
	end

endmodule

FILE: tb/ascii_ball_frame_parser_test.sv
// Self-checking testbench for the BALL line parser: directed lines, then random byte traffic.
`timescale 1ns / 1ps

module ascii_ball_frame_parser_test;
	import abfp_pkg::*;

	localparam int LINE_MAX = 64;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_item;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;

	// Idling controls, in percent per cycle
	int idle_pct = 0;
	int stall_pct = 0;

	int error_count = 0;
	int items_sent = 0;

	// Bytes of the line being built, and results still owed by the block
	logic [7:0] line_bytes[$];
	out_item_t pending_results[$];

	// Predicted parser state
	logic dropping;
	int unsigned line_len;
	phase_t line_phase;
	logic neg_sign;
	int unsigned magnitude;
	logic line_bad;
	logic text_ended;
	int unsigned field_idx;
	logic [15:0] field_vals[FIELD_COUNT];
	logic [15:0] pub_vals[FIELD_COUNT];
	logic [31:0] pub_stamp;
	logic [31:0] frame_total;
	logic [31:0] error_total;
	logic byte_ignored;

	ascii_ball_frame_parser #(
		.LINE_BUF_SIZE(LINE_MAX)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	always #10 clk = ~clk;

	// Receiver back-pressure
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// ---------------------------------------------------------------- predictor

	task automatic clear_line();
		line_len = 0;
		line_phase = PH_B;
		neg_sign = 1'b0;
		magnitude = 0;
		line_bad = 1'b0;
		text_ended = 1'b0;
		field_idx = 0;
	endtask

	task automatic reset_model();
		dropping = 1'b0;
		clear_line();
		foreach (field_vals[i]) begin
			field_vals[i] = '0;
			pub_vals[i] = '0;
		end
		pub_vals[1] = 16'hFFFF;
		pub_stamp = '0;
		frame_total = '0;
		error_total = '0;
	endtask

	function automatic logic [15:0] signed_value();
		return 16'(neg_sign ? (32'd0 - magnitude) : magnitude);
	endfunction

	function automatic out_item_t snapshot(input status_t st);
		out_item_t r;
		r.status = st;
		r.target_valid = pub_vals[0][0];
		r.x_pos = pub_vals[1];
		r.err_m11 = pub_vals[2];
		r.err_m5 = pub_vals[3];
		r.err_zero = pub_vals[4];
		r.err_p5 = pub_vals[5];
		r.err_p11 = pub_vals[6];
		r.stamp_ms = pub_stamp;
		r.frames_seen = frame_total;
		r.errors_seen = error_total;
		return r;
	endfunction

	// Accumulate one decimal digit with the signed 16-bit range check
	task automatic take_digit(input int unsigned d);
		int unsigned lim;
		int unsigned nxt;
		lim = neg_sign ? 32768 : 32767;
		nxt = magnitude * 10 + d;
		if (nxt > lim) begin
			line_bad = 1'b1;
		end else begin
			magnitude = nxt;
			line_phase = PH_DIGITS;
		end
	endtask

	// Advance the line syntax by one parsable byte
	task automatic feed_syntax(input logic [7:0] b);
		logic is_digit;
		logic [7:0] hdr;
		is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
		if (line_phase <= PH_L2) begin
			case (line_phase)
				PH_B: hdr = CH_B;
				PH_A: hdr = CH_A;
				default: hdr = CH_L;
			endcase
			if (b == hdr) line_phase = phase_t'(line_phase + 1);
			else line_bad = 1'b1;
		end else if (line_phase == PH_COMMA) begin
			if (b == CH_COMMA) begin
				line_phase = PH_FIELD_START;
				field_idx = 0;
			end else begin
				line_bad = 1'b1;
			end
		end else if (line_phase == PH_FIELD_START) begin
			neg_sign = 1'b0;
			magnitude = 0;
			if (b == CH_MINUS) begin
				neg_sign = 1'b1;
				line_phase = PH_AFTER_MINUS;
			end else if (is_digit) begin
				take_digit(b - CH_ZERO);
			end else begin
				line_bad = 1'b1;
			end
		end else if (line_phase == PH_AFTER_MINUS) begin
			if (is_digit) take_digit(b - CH_ZERO);
			else line_bad = 1'b1;
		end else begin
			if (is_digit) begin
				take_digit(b - CH_ZERO);
			end else if (b == CH_COMMA && field_idx + 1 < FIELD_COUNT) begin
				field_vals[field_idx] = signed_value();
				field_idx++;
				line_phase = PH_FIELD_START;
			end else begin
				line_bad = 1'b1;
			end
		end
	endtask

	// Work out the effect of one accepted byte; queue any result it causes
	task automatic parse_byte(input in_item_t it);
		logic ok;
		byte_ignored = 1'b0;
		if (it.rx_byte == CH_CR) begin
			byte_ignored = 1'b1;
		end else if (it.rx_byte == CH_LF) begin
			if (dropping) begin
				dropping = 1'b0;
				clear_line();
				byte_ignored = 1'b1;
			end else begin
				ok = !line_bad && line_phase == PH_DIGITS && field_idx == FIELD_COUNT - 1;
				if (ok) begin
					field_vals[FIELD_COUNT - 1] = signed_value();
					if (field_vals[0] > 16'd1) ok = 1'b0;
				end
				if (ok) begin
					foreach (pub_vals[i]) pub_vals[i] = field_vals[i];
					pub_stamp = it.time_ms;
					frame_total = (frame_total + 1 == 0) ? 32'd1 : frame_total + 1;
				end else begin
					error_total++;
				end
				clear_line();
				pending_results.push_back(snapshot(ok ? ST_FRAME : ST_PARSE_FAIL));
			end
		end else if (dropping) begin
			byte_ignored = 1'b1;
		end else if (line_len >= LINE_MAX - 1) begin
			clear_line();
			dropping = 1'b1;
			error_total++;
			pending_results.push_back(snapshot(ST_TOO_LONG));
		end else begin
			line_len++;
			if (!text_ended && !line_bad) begin
				if (it.rx_byte == CH_NUL) text_ended = 1'b1;
				else feed_syntax(it.rx_byte);
			end
		end
	endtask

	// ---------------------------------------------------------------- checking

	task automatic compare_result(input out_item_t want, input out_item_t got);
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			error_count++;
		end
		if (got.target_valid !== want.target_valid) begin
			$error("target_valid: expected %0d, got %0d", want.target_valid, got.target_valid);
			error_count++;
		end
		if (got.x_pos !== want.x_pos) begin
			$error("x_pos: expected %0d, got %0d", want.x_pos, got.x_pos);
			error_count++;
		end
		if (got.err_m11 !== want.err_m11) begin
			$error("err_m11: expected %0d, got %0d", want.err_m11, got.err_m11);
			error_count++;
		end
		if (got.err_m5 !== want.err_m5) begin
			$error("err_m5: expected %0d, got %0d", want.err_m5, got.err_m5);
			error_count++;
		end
		if (got.err_zero !== want.err_zero) begin
			$error("err_zero: expected %0d, got %0d", want.err_zero, got.err_zero);
			error_count++;
		end
		if (got.err_p5 !== want.err_p5) begin
			$error("err_p5: expected %0d, got %0d", want.err_p5, got.err_p5);
			error_count++;
		end
		if (got.err_p11 !== want.err_p11) begin
			$error("err_p11: expected %0d, got %0d", want.err_p11, got.err_p11);
			error_count++;
		end
		if (got.stamp_ms !== want.stamp_ms) begin
			$error("stamp_ms: expected %0d, got %0d", want.stamp_ms, got.stamp_ms);
			error_count++;
		end
		if (got.frames_seen !== want.frames_seen) begin
			$error("frames_seen: expected %0d, got %0d", want.frames_seen, got.frames_seen);
			error_count++;
		end
		if (got.errors_seen !== want.errors_seen) begin
			$error("errors_seen: expected %0d, got %0d", want.errors_seen, got.errors_seen);
			error_count++;
		end
	endtask

	// Each delivered item against the oldest outstanding prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result item: status %0d", out_item.status);
				error_count++;
			end else begin
				compare_result(pending_results.pop_front(), out_item);
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	function automatic logic [31:0] next_stamp();
		case ($urandom_range(15))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Present one byte, with a random idle gap first, and wait for it to be taken
	task automatic send_byte(input logic [7:0] b);
		in_item_t it;
		it.rx_byte = b;
		it.time_ms = next_stamp();
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_item <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		parse_byte(it);
		if (!byte_ignored) items_sent++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
	endtask

	task automatic send_line();
		foreach (line_bytes[i]) send_byte(line_bytes[i]);
		line_bytes.delete();
	endtask

	task automatic send_text(input string s);
		push_text(s);
		send_line();
	endtask

	// Decimal with optional leading zeros; zero sometimes written as -0
	task automatic push_number(input int value);
		string digits;
		int pad;
		if (value < 0 || (value == 0 && $urandom_range(7) == 0)) line_bytes.push_back(CH_MINUS);
		digits = $sformatf("%0d", (value < 0) ? -value : value);
		pad = ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0;
		repeat (pad) line_bytes.push_back(CH_ZERO);
		push_text(digits);
	endtask

	function automatic int pick_field();
		case ($urandom_range(7))
			0: return 32767;
			1: return -32768;
			2: return 0;
			3: return int'($urandom_range(20)) - 10;
			default: return int'($signed(16'($urandom)));
		endcase
	endfunction

	// Well-formed line body, no line feed
	task automatic push_good_body();
		push_text("BALL,");
		push_number($urandom_range(1));
		repeat (FIELD_COUNT - 1) begin
			line_bytes.push_back(CH_COMMA);
			push_number(pick_field());
		end
	endtask

	// Damage a line body in one of several ways
	task automatic corrupt_line();
		string sym;
		int pos;
		sym = ",-0123456789BAL";
		pos = $urandom_range(line_bytes.size() - 1);
		case ($urandom_range(6))
			0: line_bytes[pos] = 8'($urandom_range(255));
			1: line_bytes.delete(pos);
			2: line_bytes.insert(pos, sym[$urandom_range(sym.len() - 1)]);
			3: line_bytes[5] = 8'(CH_ZERO + $urandom_range(2, 9));
			4: push_text("99999");
			5: while (line_bytes.size() > pos) void'(line_bytes.pop_back());
			default: push_text(",7");
		endcase
	endtask

	task automatic build_random_line();
		int kind;
		int target;
		kind = $urandom_range(99);
		if (kind < 82) begin
			push_good_body();
			if (kind >= 55) corrupt_line();
			if ($urandom_range(19) == 0) begin
				// text cut short by a zero byte, junk after it
				line_bytes.push_back(CH_NUL);
				repeat ($urandom_range(5)) line_bytes.push_back(8'($urandom_range(255)));
			end
			if ($urandom_range(4) == 0)
				line_bytes.insert($urandom_range(line_bytes.size()), CH_CR);
		end else if (kind < 94) begin
			repeat ($urandom_range(40)) line_bytes.push_back(8'($urandom_range(255)));
		end else begin
			push_good_body();
			target = $urandom_range(60, 90);
			while (line_bytes.size() < target)
				line_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
		end
		line_bytes.push_back(CH_LF);
	endtask

	// Good line padded with leading zeros in its last field to an exact length
	task automatic push_padded_body(input int len);
		push_text("BALL,1,1,2,3,4,5,6");
		while (line_bytes.size() < len) line_bytes.insert(line_bytes.size() - 1, CH_ZERO);
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_good_frames();
		send_text("BALL,0,-32768,32767,-32768,32767,0,-0\n");
		send_text("BALL,1,32767,-1,00012,-00000,5,9\r\n");
		send_text("BA\rLL,1,0,0,0,0,0,0\n");
		send_text("BALL,-0,7,-7,70,-70,700,-700\n");
		// zero byte after a complete line: the rest is not parsed
		push_text("BALL,1,11,22,33,44,55,66");
		line_bytes.push_back(CH_NUL);
		push_text("zz,");
		line_bytes.push_back(8'hFF);
		push_text("\n");
		send_line();
	endtask

	task automatic test_parse_failures();
		send_text("\n");
		send_text("BALL,2,1,1,1,1,1,1\n");
		send_text("BALL,-1,1,1,1,1,1,1\n");
		send_text("BALL,1,32768,1,1,1,1,1\n");
		send_text("BALL,1,1,-32769,1,1,1,1\n");
		send_text("BALL,1,1,1,1,1,1,1,\n");
		send_text("BALL,1,1,1,1,1,1,1x\n");
		send_text("BALL,1,1,1,1,1,1\n");
		send_text("BALL,1,-,1,1,1,1,1\n");
		send_text("BALL,1,1,1,1,1,1,-\n");
		send_text("BALX,1,1,1,1,1,1,1\n");
		send_text("ball,1,1,1,1,1,1,1\n");
		send_text("BALL\n");
		// byte with the top bit set
		push_text("BALL,1,1,1,1,1,1,");
		line_bytes.push_back(8'h80);
		push_text("\n");
		send_line();
		// zero byte too early in the line
		push_text("BALL,1,1,1");
		line_bytes.push_back(CH_NUL);
		push_text(",1,1,1,1\n");
		send_line();
	endtask

	task automatic test_overlong_lines();
		// longest line that is still accepted
		push_padded_body(LINE_MAX - 1);
		line_bytes.insert(10, CH_CR);
		push_text("\n");
		send_line();
		// one byte too many; the terminating line feed is swallowed
		push_padded_body(LINE_MAX);
		line_bytes.insert(7, CH_CR);
		push_text("\n");
		send_line();
		send_text("BALL,1,3,3,3,3,3,3\n");
		// long junk with a zero byte first, then an empty line
		line_bytes.push_back(CH_NUL);
		repeat (80) line_bytes.push_back(8'($urandom_range(8'h0E, 8'hFF)));
		push_text("\n\n");
		send_line();
	endtask

	task automatic test_random_traffic(input int idle, input int stall, input int count);
		int target;
		idle_pct = idle;
		stall_pct = stall;
		target = items_sent + count;
		while (items_sent < target) begin
			build_random_line();
			send_line();
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		reset_model();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_good_frames();
		test_parse_failures();
		test_overlong_lines();
		test_random_traffic(0, 0, 306);
		test_random_traffic(88, 0, 306);
		test_random_traffic(0, 88, 306);
		test_random_traffic(36, 36, 307);

		// Drain
		@(negedge clk);
		in_valid <= 1'b0;
		stall_pct = 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: ascii_ball_frame_parser.f
design/abfp_pkg.sv
design/abfp_line_step.sv
design/abfp_record.sv
design/ascii_ball_frame_parser.sv
tb/ascii_ball_frame_parser_test.sv
